### hw/rtl/mntd_pkg.sv
// mntd_pkg: shared types, constants and tables for the MIDI note to tone divisor
// no dependencies; imported by every module of the block
package mntd_pkg;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SILENCE = 2'd1,
    ACT_TONE    = 2'd2
  } mntd_action_t;

  // message types in the high nibble of the status byte
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_SYSTEM   = 4'hF;

  localparam logic [6:0] A4_KEY      = 7'd69;
  localparam logic [6:0] LOWEST_KEY  = 7'd14;
  localparam logic [21:0] A4_FREQ    = 22'd440;
  // 440 Hz moved up by 16 bits, the starting point below A4
  localparam logic [24:0] A4_FREQ_UP = 25'd28835840;
  // timer input clock in u21f8
  localparam logic [28:0] TIMER_CLOCK = 29'd305454507;

  localparam int SEMITONES = 12;
  localparam logic [7:0] SEMITONE_FRAC [SEMITONES] = '{
    8'd0, 8'd15, 8'd31, 8'd48, 8'd67, 8'd86,
    8'd106, 8'd128, 8'd150, 8'd175, 8'd200, 8'd227
  };

  localparam int FIFO_DEPTH = 4;
  localparam int D1_STEPS   = 25;
  localparam int D2_STEPS   = 16;

  typedef struct packed {
    mntd_action_t action;
    logic         accepted;
  } mntd_tag_t;

  // one classified event on its way from the front to the dividers
  typedef struct packed {
    mntd_tag_t   tag;
    logic [24:0] dividend;
    logic [8:0]  divisor;
  } mntd_job_t;

endpackage

### hw/rtl/midi_note_to_tone_divisor.sv
// midi_note_to_tone_divisor: top level, front classifier, event queue and divider pipeline
// depends on mntd_pkg, mntd_front, mntd_fifo, mntd_back
//
// Takes one MIDI event (status, key, velocity) per cycle unless in_full is high, and returns
// one result per event, in order: no change, silence, or start a tone with a 16-bit timer
// divisor. Only channel 0 is served; system messages are ignored, out-of-range data and
// note-on keys below 14 are refused. The note frequency is built from A4 = 440 Hz by octave
// shifts and a semitone table, then the timer input clock is divided by it. Throughput is
// one event per cycle while results are popped. An accepted event passes the front register,
// the queue, a 25-stage frequency divider and a 16-stage divisor divider (one quotient bit
// per stage) and the result register before it reaches the out_ ports. A result not popped
// holds the divider pipeline; the front keeps filling the four-entry queue meanwhile.
module midi_note_to_tone_divisor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_note_key,
  input  logic [7:0]  in_note_velocity,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_tone_action,
  output logic [15:0] out_tone_divisor,
  output logic        out_event_accepted
);
  import mntd_pkg::*;

  logic      front_valid;
  mntd_job_t front_job;
  logic      q_full;
  logic      q_empty;
  logic      q_take;
  mntd_job_t q_job;

  mntd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_status_byte   (in_status_byte),
    .in_note_key      (in_note_key),
    .in_note_velocity (in_note_velocity),
    .job_valid        (front_valid),
    .job              (front_job),
    .job_full         (q_full)
  );

  mntd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_data  (front_job),
    .full     (q_full),
    .rd_take  (q_take),
    .rd_data  (q_job),
    .empty    (q_empty)
  );

  mntd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_empty          (q_empty),
    .job                (q_job),
    .job_take           (q_take),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_tone_action    (out_tone_action),
    .out_tone_divisor   (out_tone_divisor),
    .out_event_accepted (out_event_accepted)
  );

endmodule

### hw/rtl/mntd_front.sv
// mntd_front: accepts MIDI events, classifies them and prepares the frequency division
// depends on mntd_pkg
module mntd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_status_byte,
  input  logic [7:0]          in_note_key,
  input  logic [7:0]          in_note_velocity,
  output logic                job_valid,
  output mntd_pkg::mntd_job_t job,
  input  logic                job_full
);
  import mntd_pkg::*;

  logic         front_v_r;
  logic         front_v_nxt;
  mntd_job_t    job_r;
  mntd_job_t    job_nxt;
  logic         adv;
  logic         take;
  logic         is_sys;
  logic         ch0;
  logic         note_off;
  logic         note_on;
  logic [6:0]   key7;
  logic         above_a4;
  logic [6:0]   delta;
  logic [2:0]   octave;
  logic [6:0]   rem7;
  logic [3:0]   semi;
  logic [8:0]   mult;
  logic [21:0]  base_hi;
  logic [21:0]  freq_hi;
  mntd_tag_t    tag;

  assign adv  = !front_v_r || !job_full;
  assign take = in_push && adv;
  assign in_full = !adv;

  // classification
  assign is_sys   = in_status_byte[7:4] == MSG_SYSTEM;
  assign ch0      = is_sys || (in_status_byte[3:0] == 4'h0);
  assign note_off = !is_sys && (in_status_byte[7:4] == MSG_NOTE_OFF);
  assign note_on  = !is_sys && (in_status_byte[7:4] == MSG_NOTE_ON);

  always_comb begin
    tag.action   = ACT_NONE;
    tag.accepted = 1'b1;
    if (!ch0 || !(note_off || note_on)) begin
      tag.action   = ACT_NONE;
      tag.accepted = 1'b1;
    end else if (in_note_key[7] || in_note_velocity[7]) begin
      tag.action   = ACT_NONE;
      tag.accepted = 1'b0;
    end else if (note_off || (in_note_velocity == 8'd0)) begin
      tag.action   = ACT_SILENCE;
      tag.accepted = 1'b1;
    end else if (in_note_key[6:0] < LOWEST_KEY) begin
      tag.action   = ACT_NONE;
      tag.accepted = 1'b0;
    end else begin
      tag.action   = ACT_TONE;
      tag.accepted = 1'b1;
    end
  end

  // octave and semitone from the distance to A4
  assign key7     = in_note_key[6:0];
  assign above_a4 = key7 > A4_KEY;
  assign delta    = above_a4 ? (key7 - A4_KEY) : (A4_KEY - key7);
  assign octave   = 3'(delta >= 7'd12) + 3'(delta >= 7'd24) + 3'(delta >= 7'd36)
                  + 3'(delta >= 7'd48) + 3'(delta >= 7'd60);
  assign rem7     = delta - (7'(octave) * 7'd12);
  assign semi     = rem7[3:0];
  assign mult     = {1'b1, SEMITONE_FRAC[semi]};
  assign base_hi  = A4_FREQ << octave;
  assign freq_hi  = base_hi * 22'(mult);

  always_comb begin
    job_nxt     = job_r;
    front_v_nxt = front_v_r;
    if (adv) begin
      front_v_nxt = take;
      job_nxt.tag = tag;
      if (above_a4) begin
        job_nxt.dividend = 25'(freq_hi);
        job_nxt.divisor  = 9'd1;
      end else begin
        job_nxt.dividend = A4_FREQ_UP >> octave;
        job_nxt.divisor  = mult;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
    job_r <= job_nxt;
  end

  assign job_valid = front_v_r;
  assign job       = job_r;

endmodule

### hw/rtl/mntd_fifo.sv
// mntd_fifo: short queue of classified events between the front and the dividers
// depends on mntd_pkg
module mntd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  input  mntd_pkg::mntd_job_t wr_data,
  output logic                full,
  input  logic                rd_take,
  output mntd_pkg::mntd_job_t rd_data,
  output logic                empty
);
  import mntd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  mntd_job_t          mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               do_wr;
  logic               do_rd;

  assign full  = count_r == CNT_W'(FIFO_DEPTH);
  assign empty = count_r == '0;
  assign do_wr = wr_valid && !full;
  assign do_rd = rd_take && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/mntd_back.sv
// mntd_back: pipelined dividers for frequency and timer divisor, plus result register
// depends on mntd_pkg
module mntd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  mntd_pkg::mntd_job_t job,
  output logic                job_take,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [1:0]          out_tone_action,
  output logic [15:0]         out_tone_divisor,
  output logic                out_event_accepted
);
  import mntd_pkg::*;

  typedef struct packed {
    logic [8:0]  rem;
    logic [24:0] qd;
  } mntd_d1_t;

  typedef struct packed {
    logic [21:0] rem;
    logic [15:0] qd;
  } mntd_d2_t;

  function automatic mntd_d1_t d1_step(mntd_d1_t s, logic [8:0] d);
    logic [9:0] t;
    mntd_d1_t   r;
    t    = {s.rem, s.qd[24]};
    r.qd = {s.qd[23:0], 1'b0};
    if (t >= {1'b0, d}) begin
      t       = t - {1'b0, d};
      r.qd[0] = 1'b1;
    end
    r.rem = t[8:0];
    return r;
  endfunction

  function automatic mntd_d2_t d2_step(mntd_d2_t s, logic [21:0] d);
    logic [22:0] t;
    mntd_d2_t    r;
    t    = {s.rem, s.qd[15]};
    r.qd = {s.qd[14:0], 1'b0};
    if (t >= {1'b0, d}) begin
      t       = t - {1'b0, d};
      r.qd[0] = 1'b1;
    end
    r.rem = t[21:0];
    return r;
  endfunction

  logic          adv;
  logic          d1_v_r   [D1_STEPS];
  mntd_d1_t      d1_r     [D1_STEPS];
  logic [8:0]    d1_d_r   [D1_STEPS];
  mntd_tag_t     d1_tag_r [D1_STEPS];
  logic          d2_v_r   [D2_STEPS];
  mntd_d2_t      d2_r     [D2_STEPS];
  logic [21:0]   d2_d_r   [D2_STEPS];
  mntd_tag_t     d2_tag_r [D2_STEPS];
  logic          out_v_r;
  mntd_tag_t     out_tag_r;
  logic [15:0]   out_div_r;

  // whole pipeline moves unless a result waits and is not taken
  assign adv      = !out_v_r || out_pop;
  assign job_take = adv && !job_empty;

  for (genvar k = 0; k < D1_STEPS; k++) begin : g_d1
    logic       cur_v;
    mntd_d1_t   cur;
    logic [8:0] cur_d;
    mntd_tag_t  cur_tag;
    if (k == 0) begin : g_src
      assign cur_v   = !job_empty;
      assign cur     = '{rem: 9'd0, qd: job.dividend};
      assign cur_d   = job.divisor;
      assign cur_tag = job.tag;
    end else begin : g_mid
      assign cur_v   = d1_v_r[k-1];
      assign cur     = d1_r[k-1];
      assign cur_d   = d1_d_r[k-1];
      assign cur_tag = d1_tag_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[k] <= 1'b0;
      end else if (adv) begin
        d1_v_r[k] <= cur_v;
      end
      if (adv) begin
        d1_r[k]     <= d1_step(cur, cur_d);
        d1_d_r[k]   <= cur_d;
        d1_tag_r[k] <= cur_tag;
      end
    end
  end

  for (genvar k = 0; k < D2_STEPS; k++) begin : g_d2
    logic        cur_v;
    mntd_d2_t    cur;
    logic [21:0] cur_d;
    mntd_tag_t   cur_tag;
    if (k == 0) begin : g_src
      assign cur_v   = d1_v_r[D1_STEPS-1];
      assign cur     = '{rem: 22'(TIMER_CLOCK[28:16]), qd: TIMER_CLOCK[15:0]};
      assign cur_d   = d1_r[D1_STEPS-1].qd[21:0];
      assign cur_tag = d1_tag_r[D1_STEPS-1];
    end else begin : g_mid
      assign cur_v   = d2_v_r[k-1];
      assign cur     = d2_r[k-1];
      assign cur_d   = d2_d_r[k-1];
      assign cur_tag = d2_tag_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[k] <= 1'b0;
      end else if (adv) begin
        d2_v_r[k] <= cur_v;
      end
      if (adv) begin
        d2_r[k]     <= d2_step(cur, cur_d);
        d2_d_r[k]   <= cur_d;
        d2_tag_r[k] <= cur_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= d2_v_r[D2_STEPS-1];
    end
    if (adv) begin
      out_tag_r <= d2_tag_r[D2_STEPS-1];
      out_div_r <= (d2_tag_r[D2_STEPS-1].action == ACT_TONE) ?
                   d2_r[D2_STEPS-1].qd : 16'd0;
    end
  end

  assign out_empty          = !out_v_r;
  assign out_tone_action    = out_tag_r.action;
  assign out_tone_divisor   = out_div_r;
  assign out_event_accepted = out_tag_r.accepted;

endmodule
